@@ rtl/stg_pkg.sv @@
// Shared types and constants for the square tone generator with soft ramp.
package stg_pkg;

  localparam int unsigned RateW   = 16;
  localparam int unsigned AmpW    = 9;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned HalfW   = 15;
  localparam int unsigned RemainW = 22;
  localparam int unsigned DivW    = 32;
  localparam int unsigned DvsW    = 17;
  localparam int unsigned StepW   = 5;
  localparam int unsigned RecipW  = 29;
  localparam int unsigned ScaleW  = DivW + RecipW;
  localparam int unsigned MsShift = 38;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_PLAY = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [1:0] CFG_SAMPLE_RATE  = 2'd0;
  localparam logic [1:0] CFG_AMPLITUDE    = 2'd1;
  localparam logic [1:0] CFG_CENTER_LEVEL = 2'd2;

  localparam logic [RateW-1:0]   RESET_SAMPLE_RATE  = 16'd11025;
  localparam logic [AmpW-1:0]    RESET_AMPLITUDE    = 9'd96;
  localparam logic [LevelW-1:0]  RESET_CENTER_LEVEL = 10'd512;
  localparam logic [RecipW-1:0]  MS_RECIP           = 29'h10624DD3;
  localparam logic [RemainW-1:0] REMAIN_MAX         = 22'h3FFFFF;
  localparam logic [LevelW-1:0]  LEVEL_MAX          = 10'h3FF;

  typedef struct packed {
    logic [1:0]       kind;
    logic [RateW-1:0] tone_frequency;
    logic [RateW-1:0] tone_duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              dac_write;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic play;
    logic stop;
    logic div_step;
    logic hw_end;
  } stg_cmd_t;

  typedef struct packed {
    logic div_last;
  } stg_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_HW_DIV  = 3'b010,
    ST_HW_END  = 3'b100
  } stg_state_e;

endpackage

@@ rtl/square_tone_generator_soft_ramp_top.sv @@
// Top level of the square tone generator with soft centre ramp.
// A sample tick item yields one level item, which waits in an output register while the
// next items come in; a tick is held off while that register is full and not being read,
// and also while a play item is still being worked on. A stop item yields nothing. A play
// item runs one 32-step pass of the radix-2 divider to work out the half-wave length,
// the sample count comes from a reciprocal multiplication in the meantime, and no item is
// accepted until both are stored.
// Configuration writes are accepted in every cycle.
module square_tone_generator_soft_ramp_top import stg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [RateW-1:0] cfg_data_i
);

  stg_cmd_t cmd;
  stg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  stg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/stg_ctrl.sv @@
// Controller: handshakes, output valid and division sequencing.
module stg_ctrl import stg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  stg_sts_t   sts_i,
  output stg_cmd_t   cmd_o
);

  stg_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && ((in_kind_i != KIND_TICK) || out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.tick     = accept && (in_kind_i == KIND_TICK);
    cmd_o.play     = accept && (in_kind_i == KIND_PLAY);
    cmd_o.stop     = accept && (in_kind_i == KIND_STOP);
    cmd_o.div_step = (state_q == ST_HW_DIV);
    cmd_o.hw_end   = (state_q == ST_HW_END);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (cmd_o.play) state_d = ST_HW_DIV;
      ST_HW_DIV:  if (sts_i.div_last) state_d = ST_HW_END;
      ST_HW_END:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/stg_dp.sv @@
// Datapath: configuration, tone state, divider, sample count scaling and level generation.
module stg_dp import stg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [RateW-1:0] cfg_data_i,
  input  in_item_t         in_item_i,
  input  stg_cmd_t         cmd_i,
  output stg_sts_t         sts_o,
  output out_item_t        out_item_o
);

  logic [RateW-1:0]   rate_q;
  logic [AmpW-1:0]    amp_q;
  logic [LevelW-1:0]  center_q;
  logic [HalfW-1:0]   half_q, half_d;
  logic [RemainW-1:0] remain_q, remain_d;
  logic               forever_q, forever_d;
  logic [HalfW-1:0]   phase_q, phase_d;
  logic               wave_q, wave_d;
  logic [LevelW-1:0]  ramp_q, ramp_d;
  logic [LevelW-1:0]  last_q, last_d;
  logic               last_vld_q, last_vld_d;
  logic               freq_nz_q;
  logic [DivW-1:0]    prod_q;
  logic [ScaleW-1:0]  recip_q;
  logic [DivW-1:0]    dq_q, dq_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [StepW-1:0]   step_q;
  out_item_t          out_q, out_d;

  logic [DvsW:0]      shifted;
  logic [DvsW+1:0]    diff;
  logic               ge;
  logic               sounding, toggle;
  logic [HalfW-1:0]   phase_inc;
  logic [LevelW-1:0]  ramp_n, lvl;
  logic [LevelW:0]    sum_hi;
  logic [LevelW-1:0]  amp_ext;

  assign shifted = {rem_q, dq_q[DivW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[DvsW+1];
  assign sts_o.div_last = (step_q == {StepW{1'b1}});

  assign amp_ext   = {1'b0, amp_q};
  assign sounding  = (half_q != '0) && (forever_q || (remain_q != '0));
  assign phase_inc = phase_q + 1'b1;
  assign toggle    = sounding && (phase_inc >= half_q);

  always_comb begin
    ramp_n = ramp_q;
    if (sounding) begin
      if (ramp_q < center_q) begin
        ramp_n = ramp_q + 1'b1;
      end else if (ramp_q > center_q) begin
        ramp_n = ramp_q - 1'b1;
      end
    end else if (ramp_q != '0) begin
      ramp_n = ramp_q - 1'b1;
    end
  end

  assign sum_hi = {1'b0, ramp_n} + {2'b00, amp_q};

  always_comb begin
    if (!sounding) begin
      lvl = ramp_n;
    end else if (wave_q ^ toggle) begin
      lvl = sum_hi[LevelW] ? LEVEL_MAX : sum_hi[LevelW-1:0];
    end else begin
      lvl = (ramp_n > amp_ext) ? (ramp_n - amp_ext) : '0;
    end
  end

  always_comb begin
    half_d     = half_q;
    remain_d   = remain_q;
    forever_d  = forever_q;
    phase_d    = phase_q;
    wave_d     = wave_q;
    ramp_d     = ramp_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    dq_d       = dq_q;
    dvs_d      = dvs_q;
    rem_d      = rem_q;
    out_d      = out_q;
    if (cmd_i.tick) begin
      ramp_d          = ramp_n;
      out_d.level     = lvl;
      out_d.dac_write = !last_vld_q || (lvl != last_q);
      last_d          = lvl;
      last_vld_d      = 1'b1;
      if (sounding) begin
        phase_d = toggle ? '0 : phase_inc;
        wave_d  = wave_q ^ toggle;
        if (!forever_q) begin
          remain_d = remain_q - 1'b1;
        end
      end
    end
    if (cmd_i.stop) begin
      half_d    = '0;
      forever_d = 1'b0;
      remain_d  = '0;
    end
    if (cmd_i.play) begin
      forever_d = (in_item_i.tone_duration_ms == '0);
      dq_d      = {{(DivW-RateW){1'b0}}, rate_q};
      dvs_d     = {in_item_i.tone_frequency, 1'b0};
      rem_d     = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
      dq_d  = {dq_q[DivW-2:0], ge};
    end
    if (cmd_i.hw_end) begin
      if (!freq_nz_q) begin
        half_d = '0;
      end else if (dq_q[HalfW-1:0] == '0) begin
        half_d = {{(HalfW-1){1'b0}}, 1'b1};
      end else begin
        half_d = dq_q[HalfW-1:0];
      end
      remain_d = (recip_q[ScaleW-1:MsShift+RemainW] != '0) ? REMAIN_MAX :
                 recip_q[MsShift+RemainW-1:MsShift];
    end
  end

  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= RESET_SAMPLE_RATE;
      amp_q      <= RESET_AMPLITUDE;
      center_q   <= RESET_CENTER_LEVEL;
      half_q     <= '0;
      remain_q   <= '0;
      forever_q  <= 1'b0;
      phase_q    <= '0;
      wave_q     <= 1'b0;
      ramp_q     <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      step_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SAMPLE_RATE:  rate_q   <= cfg_data_i;
          CFG_AMPLITUDE:    amp_q    <= cfg_data_i[AmpW-1:0];
          CFG_CENTER_LEVEL: center_q <= cfg_data_i[LevelW-1:0];
          default:          ;
        endcase
      end
      half_q     <= half_d;
      remain_q   <= remain_d;
      forever_q  <= forever_d;
      phase_q    <= phase_d;
      wave_q     <= wave_d;
      ramp_q     <= ramp_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
      if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
    recip_q <= {{(ScaleW-DivW){1'b0}}, prod_q} * {{(ScaleW-RecipW){1'b0}}, MS_RECIP};
    if (cmd_i.play) begin
      freq_nz_q <= (in_item_i.tone_frequency != '0);
      prod_q    <= {{(DivW-RateW){1'b0}}, in_item_i.tone_duration_ms} * {{(DivW-RateW){1'b0}}, rate_q};
    end
  end

endmodule
